>>> src/rtt_pkg.sv
// ============================================================================
// rtt_pkg - shared widths, constants and command types
// Widths of the round-trip-time statistics block and the command and status
// groups between its controller and datapath.
// ============================================================================
package rtt_pkg;

    localparam int RTT_BITS   = 24;
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 8;

    localparam int MEAN_W  = RTT_BITS + FRAC_BITS;
    localparam int TOTAL_W = RTT_BITS + COUNT_BITS;
    localparam int PROD_W  = 2 * MEAN_W;
    localparam int SQ_W    = 64;
    localparam int STEP_W  = $clog2(MEAN_W);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [STEP_W-1:0]     STEP_LAST = STEP_W'(MEAN_W - 1);

    typedef struct packed {
        logic load;
        logic div_step;
        logic mean_en;
        logic dev_en;
        logic mul_en;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic full;
    } t_status;

endpackage

>>> src/rtt_in_if.sv
// ============================================================================
// rtt_in_if - sample channel
// Valid/ready channel carrying one round-trip-time sample per transfer.
// ============================================================================
interface rtt_in_if;

    logic                          valid;
    logic                          ready;
    logic [rtt_pkg::RTT_BITS-1:0]  rtt_us;

    modport source (output valid, output rtt_us, input ready);
    modport sink   (input valid, input rtt_us, output ready);

endinterface

>>> src/rtt_out_if.sv
// ============================================================================
// rtt_out_if - statistics channel
// Valid/ready channel carrying one statistics report per transfer.
// ============================================================================
interface rtt_out_if;

    logic                            valid;
    logic                            ready;
    logic [rtt_pkg::COUNT_BITS-1:0]  sample_count;
    logic [rtt_pkg::RTT_BITS-1:0]    min_rtt;
    logic [rtt_pkg::RTT_BITS-1:0]    max_rtt;
    logic [rtt_pkg::TOTAL_W-1:0]     rtt_sum;
    logic [rtt_pkg::MEAN_W-1:0]      mean_rtt;
    logic [rtt_pkg::SQ_W-1:0]        sum_sq_dev;
    logic                            count_full;

    modport source (
        output valid, output sample_count, output min_rtt, output max_rtt,
        output rtt_sum, output mean_rtt, output sum_sq_dev, output count_full,
        input  ready
    );
    modport sink (
        input  valid, input sample_count, input min_rtt, input max_rtt,
        input  rtt_sum, input mean_rtt, input sum_sq_dev, input count_full,
        output ready
    );

endinterface

>>> src/rtt_ctrl.sv
// ============================================================================
// rtt_ctrl - sequencing controller
// One-hot state machine that steps the datapath through accept, divide,
// mean update, deviation, multiply and commit, and owns the output valid.
// ============================================================================
module rtt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  rtt_pkg::t_status i_status,
    output rtt_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_MEAN   = 6'b000100,
        S_DEV    = 6'b001000,
        S_MUL    = 6'b010000,
        S_COMMIT = 6'b100000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [rtt_pkg::STEP_W-1:0]  r_step;
    logic [rtt_pkg::STEP_W-1:0]  n_step;
    logic                        r_out_valid;
    logic                        n_out_valid;
    rtt_pkg::t_cmd               w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_status.full ? S_COMMIT : S_DIV;
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_step == rtt_pkg::STEP_LAST) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                w_cmd.mean_en = 1'b1;
                n_state       = S_DEV;
            end
            S_DEV: begin
                w_cmd.dev_en = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                w_cmd.mul_en = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_step = (r_state == S_DIV) ? r_step + rtt_pkg::STEP_W'(1) : '0;
        if (w_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

>>> src/rtt_dp.sv
// ============================================================================
// rtt_dp - statistics datapath
// Running statistics registers, radix-2 restoring divider for the mean step,
// deviation product and saturating squared-deviation accumulator.
// ============================================================================
module rtt_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rtt_pkg::t_cmd                   i_cmd,
    input  logic [rtt_pkg::RTT_BITS-1:0]    i_rtt_us,
    output rtt_pkg::t_status                o_status,
    output logic [rtt_pkg::COUNT_BITS-1:0]  o_sample_count,
    output logic [rtt_pkg::RTT_BITS-1:0]    o_min_rtt,
    output logic [rtt_pkg::RTT_BITS-1:0]    o_max_rtt,
    output logic [rtt_pkg::TOTAL_W-1:0]     o_rtt_sum,
    output logic [rtt_pkg::MEAN_W-1:0]      o_mean_rtt,
    output logic [rtt_pkg::SQ_W-1:0]        o_sum_sq_dev,
    output logic                            o_count_full
);

    localparam int CW = rtt_pkg::COUNT_BITS;
    localparam int MW = rtt_pkg::MEAN_W;

    // statistics state
    logic [CW-1:0]                 r_count;
    logic [rtt_pkg::RTT_BITS-1:0]  r_min;
    logic [rtt_pkg::RTT_BITS-1:0]  r_max;
    logic [rtt_pkg::TOTAL_W-1:0]   r_total;
    logic [MW-1:0]                 r_mean;
    logic [rtt_pkg::SQ_W-1:0]      r_sq;
    logic                          r_out_full;

    // per-sample working registers
    logic [rtt_pkg::RTT_BITS-1:0]  r_x;
    logic                          r_full;
    logic                          r_neg;
    logic [MW-1:0]                 r_d1;
    logic [CW-1:0]                 r_n;
    logic [CW-1:0]                 r_rem;
    logic [MW-1:0]                 r_quo;
    logic [MW-1:0]                 r_nm;
    logic [MW-1:0]                 r_d2;
    logic [rtt_pkg::PROD_W-1:0]    r_prod;

    logic [MW-1:0]                 w_sx_in;
    logic                          w_neg_in;
    logic [MW-1:0]                 w_sx;
    logic [CW:0]                   w_trial;
    logic                          w_ge;
    logic [CW:0]                   w_rem_next;
    logic [rtt_pkg::SQ_W-1:0]      w_add;
    logic [rtt_pkg::SQ_W:0]        w_sum;
    logic [rtt_pkg::PROD_W-1:0]    w_prod;

    assign w_sx_in    = MW'(i_rtt_us) << rtt_pkg::FRAC_BITS;
    assign w_neg_in   = w_sx_in < r_mean;
    assign w_sx       = MW'(r_x) << rtt_pkg::FRAC_BITS;
    assign w_trial    = {r_rem, r_quo[MW-1]};
    assign w_ge       = w_trial >= {1'b0, r_n};
    assign w_rem_next = w_ge ? (w_trial - {1'b0, r_n}) : w_trial;
    assign w_prod     = r_d1 * r_d2;
    assign w_add      = rtt_pkg::SQ_W'(r_prod >> rtt_pkg::FRAC_BITS);
    assign w_sum      = {1'b0, r_sq} + {1'b0, w_add};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_rtt_us;
            r_full <= (r_count == rtt_pkg::COUNT_MAX);
            r_neg  <= w_neg_in;
            r_d1   <= w_neg_in ? (r_mean - w_sx_in) : (w_sx_in - r_mean);
            r_n    <= r_count + CW'(1);
            r_rem  <= '0;
            r_quo  <= w_neg_in ? (r_mean - w_sx_in) : (w_sx_in - r_mean);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_rem_next[CW-1:0];
            r_quo <= {r_quo[MW-2:0], w_ge};
        end
        if (i_cmd.mean_en) begin
            r_nm <= r_neg ? (r_mean - r_quo) : (r_mean + r_quo);
        end
        if (i_cmd.dev_en) begin
            r_d2 <= r_neg ? (r_nm - w_sx) : (w_sx - r_nm);
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_min      <= '0;
            r_max      <= '0;
            r_total    <= '0;
            r_mean     <= '0;
            r_sq       <= '0;
            r_out_full <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_full <= r_full;
            if (!r_full) begin
                r_count <= r_n;
                if (r_min == '0 || r_x < r_min) begin
                    r_min <= r_x;
                end
                if (r_x > r_max) begin
                    r_max <= r_x;
                end
                r_total <= r_total + rtt_pkg::TOTAL_W'(r_x);
                r_mean  <= r_nm;
                r_sq    <= w_sum[rtt_pkg::SQ_W] ? '1 : w_sum[rtt_pkg::SQ_W-1:0];
            end
        end
    end

    assign o_status.full  = (r_count == rtt_pkg::COUNT_MAX);
    assign o_sample_count = r_count;
    assign o_min_rtt      = r_min;
    assign o_max_rtt      = r_max;
    assign o_rtt_sum      = r_total;
    assign o_mean_rtt     = r_mean;
    assign o_sum_sq_dev   = r_sq;
    assign o_count_full   = r_out_full;

endmodule

>>> src/rtt_running_statistics_core.sv
// ============================================================================
// rtt_running_statistics_core - running round-trip-time statistics
// Count, minimum, maximum, total, running mean and sum of squared deviations.
// ============================================================================
// One report comes out for every sample taken in. From its transfer until the
// next sample can be taken, a sample passes through the accept state, the
// one-bit-per-cycle divider that forms the mean step (a quotient bit for each
// of the 32 bits of the fixed-point mean), then mean update, deviation,
// multiply and commit. A sample that arrives once the count has saturated
// goes from accept straight to commit and reports unchanged statistics with
// count_full set. The report register lets the next sample start while a
// report waits; that sample's commit waits until the report is transferred.
module rtt_running_statistics_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtt_in_if.sink    i_in,
    rtt_out_if.source o_out
);

    rtt_pkg::t_cmd    w_cmd;
    rtt_pkg::t_status w_status;

    rtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rtt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_rtt_us       (i_in.rtt_us),
        .o_status       (w_status),
        .o_sample_count (o_out.sample_count),
        .o_min_rtt      (o_out.min_rtt),
        .o_max_rtt      (o_out.max_rtt),
        .o_rtt_sum      (o_out.rtt_sum),
        .o_mean_rtt     (o_out.mean_rtt),
        .o_sum_sq_dev   (o_out.sum_sq_dev),
        .o_count_full   (o_out.count_full)
    );

endmodule

>>> src/rtt_chk.sv
// ============================================================================
// rtt_chk - port-level checks
// Checks on the statistics block as seen from its channels.
// ============================================================================
module rtt_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [rtt_pkg::COUNT_BITS-1:0]  i_sample_count,
    input logic [rtt_pkg::RTT_BITS-1:0]    i_min_rtt,
    input logic [rtt_pkg::RTT_BITS-1:0]    i_max_rtt,
    input logic [rtt_pkg::TOTAL_W-1:0]     i_rtt_sum,
    input logic [rtt_pkg::SQ_W-1:0]        i_sum_sq_dev,
    input logic                            i_count_full
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sum_sq_dev)
            && $stable(i_sample_count) && $stable(i_count_full))
        else $error("report changed before transfer");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while previous one in progress");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_count_full |-> i_sample_count == rtt_pkg::COUNT_MAX)
        else $error("sample dropped before count saturated");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_min_rtt <= i_max_rtt
            && rtt_pkg::TOTAL_W'(i_max_rtt) <= i_rtt_sum)
        else $error("minimum, maximum and total out of order");

endmodule

bind rtt_running_statistics_core rtt_chk u_rtt_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_sample_count (o_out.sample_count),
    .i_min_rtt      (o_out.min_rtt),
    .i_max_rtt      (o_out.max_rtt),
    .i_rtt_sum      (o_out.rtt_sum),
    .i_sum_sq_dev   (o_out.sum_sq_dev),
    .i_count_full   (o_out.count_full)
);

>>> bench/tb.sv
// ============================================================================
// tb - running round-trip-time statistics bench
// Drives samples into rtt_running_statistics_core and predicts each report
// (count, min, max, total, running mean, squared-deviation sum, saturation
// flag) in a small scoreboard, then compares every report field by field.
// The run starts with directed extremes and moves on to random samples under
// several idle patterns, ending with a long receiver hold-off while the
// sender runs flat out.
// ============================================================================
module tb;

    localparam int  LIMIT       = 8_000_000;
    localparam int  HOLD_CYCLES = 300;
    localparam int  TAIL_CYCLES = 60;

    typedef struct {
        logic [rtt_pkg::COUNT_BITS-1:0] cnt;
        logic [rtt_pkg::RTT_BITS-1:0]   min_v;
        logic [rtt_pkg::RTT_BITS-1:0]   max_v;
        logic [rtt_pkg::TOTAL_W-1:0]    total;
        logic [rtt_pkg::MEAN_W-1:0]     mean;
        logic [rtt_pkg::SQ_W-1:0]       m2;
        logic                           full;
    } t_stats;

    class rtt_stats_board;
        logic [rtt_pkg::COUNT_BITS-1:0] count;
        logic [rtt_pkg::RTT_BITS-1:0]   min_v;
        logic [rtt_pkg::RTT_BITS-1:0]   max_v;
        logic [rtt_pkg::TOTAL_W-1:0]    total;
        logic [rtt_pkg::MEAN_W-1:0]     mean;
        logic [rtt_pkg::SQ_W-1:0]       m2;
        t_stats                         due[$];
        int                             errors;
        int                             samples;
        int                             reports;
        int                             full_reports;
        int                             m2_sat_reports;

        function new();
            count = '0;
            min_v = '0;
            max_v = '0;
            total = '0;
            mean  = '0;
            m2    = '0;
        endfunction

        function void note_sample(logic [rtt_pkg::RTT_BITS-1:0] x);
            logic [rtt_pkg::MEAN_W-1:0] sx;
            logic [rtt_pkg::MEAN_W-1:0] d1;
            logic [rtt_pkg::MEAN_W-1:0] q;
            logic [rtt_pkg::MEAN_W-1:0] nm;
            logic [rtt_pkg::MEAN_W-1:0] d2;
            logic [127:0]               prod;
            logic [127:0]               shifted;
            logic [rtt_pkg::SQ_W-1:0]   add;
            logic [rtt_pkg::SQ_W:0]     acc;
            logic                       neg;
            t_stats                     e;
            samples++;
            e.full = 1'b0;
            if (count == rtt_pkg::COUNT_MAX) begin
                e.full = 1'b1;
            end else begin
                sx = rtt_pkg::MEAN_W'(x) << rtt_pkg::FRAC_BITS;
                neg = sx < mean;
                d1 = neg ? (mean - sx) : (sx - mean);
                q = d1 / rtt_pkg::MEAN_W'(count + 1'b1);
                nm = neg ? (mean - q) : (mean + q);
                d2 = neg ? (nm - sx) : (sx - nm);
                prod = 128'(d1) * 128'(d2);
                shifted = prod >> rtt_pkg::FRAC_BITS;
                add = (|shifted[127:rtt_pkg::SQ_W]) ? '1 : shifted[rtt_pkg::SQ_W-1:0];
                acc = {1'b0, m2} + {1'b0, add};
                m2 = acc[rtt_pkg::SQ_W] ? '1 : acc[rtt_pkg::SQ_W-1:0];
                count = count + 1'b1;
                if (min_v == '0) min_v = x;
                if (x < min_v) min_v = x;
                if (x > max_v) max_v = x;
                total = total + rtt_pkg::TOTAL_W'(x);
                mean = nm;
            end
            e.cnt   = count;
            e.min_v = min_v;
            e.max_v = max_v;
            e.total = total;
            e.mean  = mean;
            e.m2    = m2;
            due.push_back(e);
        endfunction

        function void check_field(string what, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                if (errors < 10) begin
                    $display("tb: report %0d %s mismatch: expected %0h, got %0h",
                             reports, what, want, seen);
                end
                errors++;
            end
        endfunction

        function void check_report(t_stats got);
            t_stats e;
            reports++;
            if (due.size() == 0) begin
                if (errors < 10) begin
                    $display("tb: report %0d arrived with no sample outstanding", reports);
                end
                errors++;
                return;
            end
            e = due.pop_front();
            if (e.full) full_reports++;
            if (e.m2 == '1) m2_sat_reports++;
            check_field("sample_count", 64'(e.cnt), 64'(got.cnt));
            check_field("min_rtt", 64'(e.min_v), 64'(got.min_v));
            check_field("max_rtt", 64'(e.max_v), 64'(got.max_v));
            check_field("rtt_sum", 64'(e.total), 64'(got.total));
            check_field("mean_rtt", 64'(e.mean), 64'(got.mean));
            check_field("sum_sq_dev", e.m2, got.m2);
            check_field("count_full", 64'(e.full), 64'(got.full));
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    rtt_in_if       in_ch ();
    rtt_out_if      out_ch ();
    rtt_stats_board board;

    int src_idle_pct;
    int sink_idle_pct;
    int hold_req;
    int hold_ack;
    int hold_left;
    int cycles;

    rtt_running_statistics_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end
    end

    // Check transfers and pace the receiver; a hold-off request stalls it.
    always @(posedge i_clk) begin
        t_stats got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.cnt   = out_ch.sample_count;
            got.min_v = out_ch.min_rtt;
            got.max_v = out_ch.max_rtt;
            got.total = out_ch.rtt_sum;
            got.mean  = out_ch.mean_rtt;
            got.m2    = out_ch.sum_sq_dev;
            got.full  = out_ch.count_full;
            board.check_report(got);
        end
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [rtt_pkg::RTT_BITS-1:0] draw_sample();
        case ($urandom_range(4))
            0: return rtt_pkg::RTT_BITS'($urandom);
            1: return rtt_pkg::RTT_BITS'($urandom_range(255));
            2: return '1 - rtt_pkg::RTT_BITS'($urandom_range(255));
            3: return rtt_pkg::RTT_BITS'($urandom_range(200000, 1000));
            default: return rtt_pkg::RTT_BITS'(50000 + $urandom_range(2000));
        endcase
    endfunction

    task automatic send_sample(input logic [rtt_pkg::RTT_BITS-1:0] x);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.rtt_us <= x;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_sample(x);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (board.due.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int items, input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (items) send_sample(draw_sample());
        wait_drained();
    endtask

    initial begin
        logic [rtt_pkg::RTT_BITS-1:0] directed[$];
        board = new();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.rtt_us  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero samples first so the minimum keeps being replaced, then extremes.
        directed = '{24'h000000, 24'h000000, 24'h000001, 24'hFFFFFF, 24'h000000,
                     24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h000001, 24'h000002,
                     24'hFFFFFE, 24'h123456, 24'hABCDEF, 24'h000000, 24'h000005,
                     24'h000005, 24'h000005, 24'hFFFFFF, 24'hFFFFFF, 24'h555555,
                     24'hAAAAAA};
        foreach (directed[k]) send_sample(directed[k]);
        wait_drained();

        run_phase(320, 29, 57);
        run_phase(320, 57, 29);

        // Stall the receiver while samples keep coming, so the input backs up.
        hold_req++;
        run_phase(290, 0, 0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.due.size() != 0) begin
            $display("tb: %0d reports never arrived", board.due.size());
            board.errors++;
        end
        $display("tb: %0d samples sent, %0d reports checked, over idle mixes and a %0d-cycle hold-off",
                 board.samples, board.reports, HOLD_CYCLES);
        $display("tb: %0d reports with saturated deviation sum, %0d field mismatches",
                 board.m2_sat_reports, board.errors);
        if (board.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
src/rtt_pkg.sv
src/rtt_in_if.sv
src/rtt_out_if.sv
src/rtt_ctrl.sv
src/rtt_dp.sv
src/rtt_running_statistics_core.sv
src/rtt_chk.sv
bench/tb.sv
